// ===== hdl/assert_macros.svh =====
// Assertion macros used by the postfix evaluator back end.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pfe_pkg.sv =====
// Package for the postfix expression evaluator: operation and status codes,
// character constants, the queue entry type and the character decoder. No dependencies.
package pfe_pkg;

   // Character codes recognised by the evaluator.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POW   = 8'h5E;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_ADD   = 8'h2B;
   localparam logic [7:0] CHAR_SUB   = 8'h2D;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   // Counters saturate at their top value.
   localparam int CNT_BITS = 16;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_DIGIT = 3'd1,
      OP_POW   = 3'd2,
      OP_MUL   = 3'd3,
      OP_DIV   = 3'd4,
      OP_ADD   = 3'd5,
      OP_SUB   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_COUNT     = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_DIVZERO   = 3'd4
   } status_type;

   // One classified character as it travels through the queue.
   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
      logic       last;
   } entry_type;

   // Maps a character to its operation.
   function automatic op_type classify(input logic [7:0] c);
      op_type r;
      r = OP_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) r = OP_DIGIT;
      else if (c == CHAR_POW) r = OP_POW;
      else if (c == CHAR_MUL) r = OP_MUL;
      else if (c == CHAR_DIV) r = OP_DIV;
      else if (c == CHAR_ADD) r = OP_ADD;
      else if (c == CHAR_SUB) r = OP_SUB;
      return r;
   endfunction

endpackage

// ===== hdl/postfix_expression_evaluator.sv =====
// Postfix expression evaluator: the back end pushes a digit straight onto the stack; an operator
// pops two operands and runs the arithmetic unit (add/subtract, multiply, divide, power), which
// uses a shift-add multiplier shared by multiply and power and a restoring divider. rsp_valid
// rises once a final digit, ignored character or operator has been processed and the top of
// stack has been loaded into the result register.
// Synchronous active-high reset clears control state; stack contents are left as they are.
module postfix_expression_evaluator
   import pfe_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_BITS  = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_status
);

   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   // Front end classifies and queues character beats.
   pfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   // Back end evaluates on the operand stack and returns the result.
   pfe_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

// ===== hdl/pfe_front.sv =====
// Front end: accepts character beats, classifies them and queues them.
// Depends on pfe_pkg.
module pfe_front
   import pfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       q_valid,
   output entry_type  q_entry,
   input  logic       q_pop
);

   entry_type                entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]       count_ff, count_in;
   entry_type                new_entry;
   logic                     accept;
   logic                     push;
   logic                     pop;

   // Classify the incoming beat; ignored characters are dropped unless final.
   always_comb begin
      new_entry.op    = classify(req_char_code);
      new_entry.digit = 4'(req_char_code - CHAR_ZERO);
      new_entry.last  = req_last_char;
   end

   assign req_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign accept    = req_valid & req_ready;
   assign push      = accept & ((new_entry.op != OP_NONE) | req_last_char);
   assign pop       = q_pop & q_valid;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entries_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== hdl/pfe_alu.sv =====
// Sequential arithmetic unit: add, subtract, shift-add multiply, restoring
// divide and square-and-multiply power. Depends on pfe_pkg.
module pfe_alu
   import pfe_pkg::*;
#(
   parameter int VALUE_BITS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  op_type                op,
   input  logic [VALUE_BITS-1:0] opnd_a,
   input  logic [VALUE_BITS-1:0] opnd_b,
   output logic                  done,
   output logic [VALUE_BITS-1:0] result,
   output logic                  div_zero
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   typedef enum logic [6:0] {
      A_IDLE = 7'b0000001,
      A_MUL  = 7'b0000010,
      A_DIV  = 7'b0000100,
      A_PSEL = 7'b0001000,
      A_PMR  = 7'b0010000,
      A_PMB  = 7'b0100000,
      A_DONE = 7'b1000000
   } astate_type;

   astate_type             state_ff, state_in;
   logic [VALUE_BITS-1:0]  res_ff;
   logic                   dz_ff;
   logic [VALUE_BITS-1:0]  acc_ff, mc_ff, mp_ff;
   logic [VALUE_BITS-1:0]  dvd_ff, dsr_ff, rem_ff;
   logic                   neg_ff;
   logic [CW-1:0]          cnt_ff;
   logic [VALUE_BITS-1:0]  pres_ff, pbase_ff, pexp_ff;
   logic [VALUE_BITS:0]    rem_shift;
   logic                   rem_ge;
   logic                   mul_end;
   logic [VALUE_BITS-1:0]  ones;

   assign ones      = '1;
   assign mul_end   = (mp_ff == '0);
   assign rem_shift = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign rem_ge    = (rem_shift >= {1'b0, dsr_ff});

   assign done     = (state_ff == A_DONE);
   assign result   = res_ff;
   assign div_zero = dz_ff;

   // Sequencer for the multi-cycle operations.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               unique case (op)
                  OP_MUL:  state_in = A_MUL;
                  OP_DIV:  state_in = (opnd_a == '0) ? A_DONE : A_DIV;
                  OP_POW:  state_in = opnd_a[VALUE_BITS-1] ? A_DONE : A_PSEL;
                  default: state_in = A_DONE;
               endcase
            end
         end
         A_MUL:  if (mul_end) state_in = A_DONE;
         A_DIV:  if (cnt_ff == CW'(VALUE_BITS)) state_in = A_DONE;
         A_PSEL: begin
            if (pexp_ff == '0) state_in = A_DONE;
            else if (pexp_ff[0]) state_in = A_PMR;
            else state_in = A_PMB;
         end
         A_PMR: begin
            if (mul_end) begin
               state_in = (pexp_ff[VALUE_BITS-1:1] == '0) ? A_DONE : A_PMB;
            end
         end
         A_PMB:  if (mul_end) state_in = A_PSEL;
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         dz_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == A_IDLE && start) begin
            dz_ff <= (op == OP_DIV) && (opnd_a == '0);
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         A_IDLE: begin
            if (start) begin
               case (op)
                  OP_ADD: res_ff <= opnd_b + opnd_a;
                  OP_SUB: res_ff <= opnd_b - opnd_a;
                  OP_MUL: begin
                     acc_ff <= '0;
                     mc_ff  <= opnd_b;
                     mp_ff  <= opnd_a;
                  end
                  OP_DIV: begin
                     res_ff <= '0;
                     dvd_ff <= opnd_b[VALUE_BITS-1] ? (~opnd_b + 1'b1) : opnd_b;
                     dsr_ff <= opnd_a[VALUE_BITS-1] ? (~opnd_a + 1'b1) : opnd_a;
                     neg_ff <= opnd_b[VALUE_BITS-1] ^ opnd_a[VALUE_BITS-1];
                     rem_ff <= '0;
                     cnt_ff <= '0;
                  end
                  OP_POW: begin
                     // A negative exponent only gives a non-zero power for base one or minus one.
                     if (opnd_b == VALUE_BITS'(1)) res_ff <= VALUE_BITS'(1);
                     else if (opnd_b == ones) res_ff <= opnd_a[0] ? ones : VALUE_BITS'(1);
                     else res_ff <= '0;
                     pres_ff  <= VALUE_BITS'(1);
                     pbase_ff <= opnd_b;
                     pexp_ff  <= opnd_a;
                  end
                  default: res_ff <= '0;
               endcase
            end
         end
         A_MUL: begin
            if (mul_end) begin
               res_ff <= acc_ff;
            end else begin
               acc_ff <= acc_ff + (mp_ff[0] ? mc_ff : '0);
               mc_ff  <= mc_ff << 1;
               mp_ff  <= mp_ff >> 1;
            end
         end
         A_DIV: begin
            if (cnt_ff == CW'(VALUE_BITS)) begin
               res_ff <= neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
            end else begin
               rem_ff <= rem_ge ? VALUE_BITS'(rem_shift - {1'b0, dsr_ff})
                                : rem_shift[VALUE_BITS-1:0];
               dvd_ff <= {dvd_ff[VALUE_BITS-2:0], rem_ge};
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         A_PSEL: begin
            res_ff <= pres_ff;
            acc_ff <= '0;
            mc_ff  <= pexp_ff[0] ? pres_ff : pbase_ff;
            mp_ff  <= pbase_ff;
         end
         A_PMR: begin
            if (mul_end) begin
               pres_ff <= acc_ff;
               res_ff  <= acc_ff;
               acc_ff  <= '0;
               mc_ff   <= pbase_ff;
               mp_ff   <= pbase_ff;
            end else begin
               acc_ff <= acc_ff + (mp_ff[0] ? mc_ff : '0);
               mc_ff  <= mc_ff << 1;
               mp_ff  <= mp_ff >> 1;
            end
         end
         A_PMB: begin
            if (mul_end) begin
               pbase_ff <= acc_ff;
               pexp_ff  <= pexp_ff >> 1;
            end else begin
               acc_ff <= acc_ff + (mp_ff[0] ? mc_ff : '0);
               mc_ff  <= mc_ff << 1;
               mp_ff  <= mp_ff >> 1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== hdl/pfe_back.sv =====
// Back end: operand stack, counters, error flags and the result register.
// Depends on pfe_pkg, pfe_alu and assert_macros.svh.
`include "assert_macros.svh"
module pfe_back
   import pfe_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_BITS  = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  entry_type   q_entry,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_status
);

   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int AW  = $clog2(STACK_DEPTH);

   typedef enum logic [8:0] {
      B_IDLE  = 9'b000000001,
      B_POPA  = 9'b000000010,
      B_WAITB = 9'b000000100,
      B_POPB  = 9'b000001000,
      B_EXEC  = 9'b000010000,
      B_WAIT  = 9'b000100000,
      B_PUSH  = 9'b001000000,
      B_TOP   = 9'b010000000,
      B_EMIT  = 9'b100000000
   } bstate_type;

   bstate_type             state_ff, state_in;
   logic [VALUE_BITS-1:0]  stack_mem [STACK_DEPTH];
   logic [VALUE_BITS-1:0]  rd_data_ff;
   logic [SPW-1:0]         sp_ff;
   logic [CNT_BITS-1:0]    dcnt_ff, ocnt_ff;
   logic                   ovf_ff, unf_ff, dvz_ff;
   op_type                 op_ff;
   logic                   last_ff;
   logic [VALUE_BITS-1:0]  a_ff, b_ff, v_ff;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_value_ff;
   logic [2:0]             rsp_status_ff;
   logic                   full, empty;
   logic                   take;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_BITS-1:0]  wr_data;
   logic                   emit;
   logic                   alu_done, alu_dz;
   logic [VALUE_BITS-1:0]  alu_result;
   logic [63:0]            top_wide;
   status_type             status;

   assign full    = (sp_ff == SPW'(STACK_DEPTH));
   assign empty   = (sp_ff == '0);
   assign q_pop   = (state_ff == B_IDLE);
   assign take    = q_pop & q_valid;
   assign emit    = (state_ff == B_EMIT) & (~rsp_valid_ff | rsp_ready);

   // Sequencer: one queue entry at a time.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (take) begin
               if (q_entry.op == OP_DIGIT || q_entry.op == OP_NONE) begin
                  state_in = q_entry.last ? B_TOP : B_IDLE;
               end else begin
                  state_in = B_POPA;
               end
            end
         end
         B_POPA:  state_in = B_WAITB;
         B_WAITB: state_in = B_POPB;
         B_POPB:  state_in = B_EXEC;
         B_EXEC:  state_in = B_WAIT;
         B_WAIT:  if (alu_done) state_in = B_PUSH;
         B_PUSH:  state_in = last_ff ? B_TOP : B_IDLE;
         B_TOP:   state_in = B_EMIT;
         B_EMIT:  if (emit) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Stack memory: one write port, one registered read port at the top.
   always_comb begin
      wr_addr = sp_ff[AW-1:0];
      rd_addr = AW'(sp_ff - 1'b1);
      wr_en   = ~full & ((take & (q_entry.op == OP_DIGIT)) | (state_ff == B_PUSH));
      wr_data = (state_ff == B_PUSH) ? v_ff : VALUE_BITS'(q_entry.digit);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // Stack pointer, counters and error flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         sp_ff    <= '0;
         dcnt_ff  <= '0;
         ocnt_ff  <= '0;
         ovf_ff   <= 1'b0;
         unf_ff   <= 1'b0;
         dvz_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            sp_ff   <= '0;
            dcnt_ff <= '0;
            ocnt_ff <= '0;
            ovf_ff  <= 1'b0;
            unf_ff  <= 1'b0;
            dvz_ff  <= 1'b0;
         end else begin
            if (take && q_entry.op == OP_DIGIT) begin
               if (full) ovf_ff <= 1'b1;
               else sp_ff <= sp_ff + 1'b1;
               if (dcnt_ff != '1) dcnt_ff <= dcnt_ff + 1'b1;
            end
            if (state_ff == B_POPA || state_ff == B_POPB) begin
               if (empty) unf_ff <= 1'b1;
               else sp_ff <= sp_ff - 1'b1;
            end
            if (state_ff == B_WAIT && alu_done && alu_dz) begin
               dvz_ff <= 1'b1;
            end
            if (state_ff == B_PUSH) begin
               if (full) ovf_ff <= 1'b1;
               else sp_ff <= sp_ff + 1'b1;
               if (ocnt_ff != '1) ocnt_ff <= ocnt_ff + 1'b1;
            end
         end
      end
   end

   // Operand and item registers.
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff   <= q_entry.op;
         last_ff <= q_entry.last;
      end
      if (state_ff == B_POPA) a_ff <= empty ? '0 : rd_data_ff;
      if (state_ff == B_POPB) b_ff <= empty ? '0 : rd_data_ff;
      if (state_ff == B_WAIT && alu_done) v_ff <= alu_result;
   end

   pfe_alu #(
      .VALUE_BITS (VALUE_BITS)
   ) u_alu (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == B_EXEC),
      .op       (op_ff),
      .opnd_a   (a_ff),
      .opnd_b   (b_ff),
      .done     (alu_done),
      .result   (alu_result),
      .div_zero (alu_dz)
   );

   // Status priority: count mismatch, overflow, underflow, divide by zero.
   always_comb begin
      if ({1'b0, dcnt_ff} != ({1'b0, ocnt_ff} + (CNT_BITS+1)'(1))) status = ST_COUNT;
      else if (ovf_ff) status = ST_OVERFLOW;
      else if (unf_ff) status = ST_UNDERFLOW;
      else if (dvz_ff) status = ST_DIVZERO;
      else status = ST_OK;
      top_wide = empty ? 64'd0 : 64'(rd_data_ff);
   end

   // Result register parts the back from the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit | (rsp_valid_ff & ~rsp_ready);
      end
      if (emit) begin
         rsp_value_ff  <= top_wide[31:0];
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // The stack pointer never passes the stack depth.
   `ASSERT_ALWAYS(a_sp_bound, sp_ff <= SPW'(STACK_DEPTH), "stack pointer beyond depth")
   // A delivered result leaves an empty stack and cleared counters.
   `ASSERT_NEXT(a_emit_clear, emit, sp_ff == '0 && dcnt_ff == '0 && ocnt_ff == '0,
                "state not cleared after result")
   // A result is only loaded when the output register is free or being drained.
   `ASSERT_NEXT(a_emit_valid, emit, rsp_valid_ff, "result beat lost")

endmodule
